/* sv/zab_pkg.sv */
// shared field widths and payload types of the z array builder
package zab_pkg;

  localparam int SYM_W = 8;  // one byte of text
  localparam int POS_W = 6;  // result position field
  localparam int ZV_W  = 7;  // result z value field

  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [ZV_W-1:0]  zval_t;

endpackage

/* sv/zab_text_mem.sv */
// text store: one write port, two registered read ports
module zab_text_mem #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  zab_pkg::sym_t    wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr_a,
  input  logic [IDX_W-1:0] rd_addr_b,
  output zab_pkg::sym_t    rd_data_a,
  output zab_pkg::sym_t    rd_data_b
);
  import zab_pkg::*;

  sym_t mem_r [DEPTH];
  sym_t rd_a_r;
  sym_t rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // both read ports share one enable, data held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem_r[rd_addr_a];
      rd_b_r <= mem_r[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

/* sv/z_array_builder_top.sv */
// z array builder top level: text loading, z sequencer and result output
//
// channel   dir  handshake             payload
// in_       in   in_valid / in_ready   in_symbol, in_last
// out_      out  out_valid / out_ready out_position, out_z_value, out_overflow, out_last_res
//
// loading accepts byte requests back to back; bytes beyond MAX_LEN are dropped
// computing: for each position from 1 to n-1 a window check, a clamp and a store,
// with a comparison step per byte pair on the dual-read text store, then a final check
// results: each is read from the z store, then held until taken
// in_ready is low from the closing byte until the final result is taken
// reset is synchronous; the stores need no clearing, only written entries are used
module z_array_builder_top #(
  parameter int MAX_LEN = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  zab_pkg::sym_t  in_symbol,
  input  logic           in_last,
  output logic           out_valid,
  input  logic           out_ready,
  output zab_pkg::pos_t  out_position,
  output zab_pkg::zval_t out_z_value,
  output logic           out_overflow,
  output logic           out_last_res
);
  import zab_pkg::*;

  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [2:0] {
    S_LOAD, S_START, S_CLAMP, S_CMP, S_WRITE, S_OREAD, S_OUT
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;     // stored bytes, n during compute
  logic               drop_r, drop_nxt;   // bytes dropped this string
  logic [CNT_W-1:0]   i_r, i_nxt;         // position being computed
  logic [CNT_W-1:0]   k_r, k_nxt;         // current match length
  logic [IDX_W-1:0]   l_r, l_nxt;         // window left
  logic [IDX_W-1:0]   r_r, r_nxt;         // window right
  logic               win_r, win_nxt;     // position lies inside window
  logic [IDX_W-1:0]   o_r, o_nxt;         // output position

  // z store
  logic [CNT_W-1:0]   z_mem_r [MAX_LEN];
  logic [CNT_W-1:0]   z_q_r;
  logic               z_re;
  logic [IDX_W-1:0]   z_raddr;
  logic               z_we;

  // text store ports
  logic               t_we;
  logic               t_re;
  logic [IDX_W-1:0]   t_addr_a;
  logic [IDX_W-1:0]   t_addr_b;
  sym_t               t_a;
  sym_t               t_b;

  // sequencer arithmetic
  logic               in_acc;
  logic               out_acc;
  logic               res_last;
  logic [SUM_W-1:0]   room;
  logic [SUM_W-1:0]   prior;
  logic [SUM_W-1:0]   k0;
  logic [SUM_W-1:0]   ik0;
  logic [SUM_W-1:0]   ik1;
  logic [SUM_W-1:0]   k1;
  logic [SUM_W-1:0]   reach;

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = (state_r == S_OUT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  // clamp of the earlier value to the room left in the window
  assign room  = SUM_W'(r_r) - SUM_W'(i_r) + SUM_W'(1);
  assign prior = SUM_W'(z_q_r);
  assign k0    = win_r ? ((prior < room) ? prior : room) : '0;
  assign ik0   = SUM_W'(i_r) + k0;
  // next comparison index once the current pair matched
  assign k1    = SUM_W'(k_r) + SUM_W'(1);
  assign ik1   = SUM_W'(i_r) + k1;
  // last index covered by the match just finished
  assign reach = SUM_W'(i_r) + SUM_W'(k_r) - SUM_W'(1);

  assign res_last = (CNT_W'(o_r) + CNT_W'(1) == cnt_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    drop_nxt  = drop_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    l_nxt     = l_r;
    r_nxt     = r_r;
    win_nxt   = win_r;
    o_nxt     = o_r;
    t_we      = 1'b0;
    t_re      = 1'b0;
    t_addr_a  = k_r[IDX_W-1:0];
    t_addr_b  = ik0[IDX_W-1:0];
    z_re      = 1'b0;
    z_raddr   = o_r;
    z_we      = 1'b0;
    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (cnt_r < CNT_W'(MAX_LEN)) begin
            t_we    = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last) begin
            i_nxt     = CNT_W'(1);
            l_nxt     = '0;
            r_nxt     = '0;
            o_nxt     = '0;
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        if (i_r >= cnt_r) begin
          state_nxt = S_OREAD;
        end else begin
          // fetch the earlier value mirrored inside the window
          win_nxt   = (i_r <= CNT_W'(r_r));
          z_re      = win_nxt;
          z_raddr   = i_r[IDX_W-1:0] - l_r;
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        k_nxt    = k0[CNT_W-1:0];
        t_addr_a = k0[IDX_W-1:0];
        t_addr_b = ik0[IDX_W-1:0];
        if (ik0 < SUM_W'(cnt_r)) begin
          t_re      = 1'b1;
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_CMP: begin
        // compare the pair fetched last cycle, fetch the next pair on a match
        t_addr_a = k1[IDX_W-1:0];
        t_addr_b = ik1[IDX_W-1:0];
        if (t_a == t_b) begin
          k_nxt = k1[CNT_W-1:0];
          if (ik1 < SUM_W'(cnt_r)) begin
            t_re = 1'b1;
          end else begin
            state_nxt = S_WRITE;
          end
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        z_we = 1'b1;
        if ((k_r != '0) && (reach > SUM_W'(r_r))) begin
          l_nxt = i_r[IDX_W-1:0];
          r_nxt = reach[IDX_W-1:0];
        end
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = S_START;
      end
      S_OREAD: begin
        z_re      = 1'b1;
        z_raddr   = o_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_acc) begin
          if (res_last) begin
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            l_nxt     = '0;
            r_nxt     = '0;
            state_nxt = S_LOAD;
          end else begin
            o_nxt     = o_r + IDX_W'(1);
            state_nxt = S_OREAD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
      i_r     <= '0;
      k_r     <= '0;
      l_r     <= '0;
      r_r     <= '0;
      win_r   <= 1'b0;
      o_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      l_r     <= l_nxt;
      r_r     <= r_nxt;
      win_r   <= win_nxt;
      o_r     <= o_nxt;
    end
  end

  // z store: written once per position from 1 on, read for the window and for output
  always_ff @(posedge clk) begin
    if (z_we) begin
      z_mem_r[i_r[IDX_W-1:0]] <= k_r;
    end
  end

  always_ff @(posedge clk) begin
    if (z_re) begin
      z_q_r <= z_mem_r[z_raddr];
    end
  end

  zab_text_mem #(
    .DEPTH (MAX_LEN),
    .IDX_W (IDX_W)
  ) u_text (
    .clk       (clk),
    .wr_en     (t_we),
    .wr_addr   (cnt_r[IDX_W-1:0]),
    .wr_data   (in_symbol),
    .rd_en     (t_re),
    .rd_addr_a (t_addr_a),
    .rd_addr_b (t_addr_b),
    .rd_data_a (t_a),
    .rd_data_b (t_b)
  );

  // position 0 is zero by definition and never stored
  assign out_position = POS_W'(o_r);
  assign out_z_value  = (o_r == '0) ? '0 : ZV_W'(z_q_r);
  assign out_overflow = drop_r;
  assign out_last_res = res_last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_LEN))
    else $error("byte count beyond capacity");

  a_win_in_string: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> (CNT_W'(r_r) < cnt_r))
    else $error("match window beyond string end");

  a_cmp_in_string: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (SUM_W'(i_r) + SUM_W'(k_r) < SUM_W'(cnt_r)))
    else $error("comparison beyond string end");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("loading while results pending");

  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_res) |=> (in_ready && (cnt_r == '0) && !out_overflow))
    else $error("string not cleared after final result");

endmodule

/* verif/z_array_checker.sv */
// checker for the z array builder: predicts z results from accepted bytes and compares them
module z_array_checker #(
  parameter int MAX_LEN = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  zab_pkg::sym_t  in_symbol,
  input  logic           in_last,
  input  logic           out_valid,
  input  logic           out_ready,
  input  zab_pkg::pos_t  out_position,
  input  zab_pkg::zval_t out_z_value,
  input  logic           out_overflow,
  input  logic           out_last_res,
  output int             mismatches,
  output int             pending,
  output int             results_checked,
  output int             strings_closed,
  output int             strings_overflowed
);
  import zab_pkg::*;

  typedef struct packed {
    pos_t  position;
    zval_t z_value;
    logic  overflow;
    logic  last_res;
  } z_entry_t;

  z_entry_t    z_expect_q[$];
  sym_t        text_copy[MAX_LEN];
  int unsigned text_len;
  logic        text_dropped;

  // z array of the stored text, one queued entry per position
  task automatic queue_z_entries();
    int unsigned z[MAX_LEN];
    int unsigned win_lo;
    int unsigned win_hi;
    int unsigned k;
    z_entry_t    e;
    win_lo = 0;
    win_hi = 0;
    z[0]   = 0;
    for (int unsigned i = 1; i < text_len; i++) begin
      k = 0;
      if (i <= win_hi) begin
        k = z[i - win_lo];
        if (k > win_hi - i + 1) k = win_hi - i + 1;
      end
      while (i + k < text_len && text_copy[k] == text_copy[i + k]) k++;
      z[i] = k;
      if (k > 0 && i + k - 1 > win_hi) begin
        win_lo = i;
        win_hi = i + k - 1;
      end
    end
    for (int unsigned i = 0; i < text_len; i++) begin
      e.position = pos_t'(i);
      e.z_value  = zval_t'(z[i]);
      e.overflow = text_dropped;
      e.last_res = (i + 1 == text_len);
      z_expect_q.push_back(e);
    end
  endtask

  always @(posedge clk) begin : track
    z_entry_t head;
    if (!rst_n) begin
      text_len     = 0;
      text_dropped = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (z_expect_q.size() == 0) begin
          $error("unexpected result at position %0d, z_value %0d", out_position, out_z_value);
          mismatches++;
        end else begin
          head = z_expect_q.pop_front();
          if (out_position !== head.position) begin
            $error("position: expected %0d, actual %0d", head.position, out_position);
            mismatches++;
          end
          if (out_z_value !== head.z_value) begin
            $error("z_value: expected %0d, actual %0d", head.z_value, out_z_value);
            mismatches++;
          end
          if (out_overflow !== head.overflow) begin
            $error("overflow: expected %0b, actual %0b", head.overflow, out_overflow);
            mismatches++;
          end
          if (out_last_res !== head.last_res) begin
            $error("last_res: expected %0b, actual %0b", head.last_res, out_last_res);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (text_len < MAX_LEN) begin
          text_copy[text_len] = in_symbol;
          text_len++;
        end else begin
          text_dropped = 1'b1;
        end
        if (in_last) begin
          queue_z_entries();
          strings_closed++;
          if (text_dropped) strings_overflowed++;
          text_len     = 0;
          text_dropped = 1'b0;
        end
      end
    end
    pending = z_expect_q.size();
  end

  final begin
    if (z_expect_q.size() != 0)
      $error("%0d z results never arrived", z_expect_q.size());
  end

endmodule

/* verif/z_array_builder_top_tb.sv */
// testbench top for the z array builder: stimulus, flow control, watchdog and verdict
module z_array_builder_top_tb;
  import zab_pkg::*;

  localparam int MAX_LEN      = 64;
  localparam int IDLE_PCT     = 10;    // chance of a gap per request or a stall per cycle
  localparam int HOLD_CYCLES  = 400;   // one long receiver hold-off
  localparam int HOLD_AFTER   = 40;    // results taken before the hold-off starts
  localparam int STALL_LIMIT  = 4000;  // cycles with no request moving on either side
  localparam int DRAIN_CYCLES = 40;    // settle time once nothing is expected
  localparam int RANDOM_ITEMS = 200;

  // shapes of random text
  typedef enum int {
    SHAPE_NOISE,     // any byte value
    SHAPE_ALPHABET,  // drawn from a few symbols, so matches are common
    SHAPE_PERIODIC   // a short repeated pattern with rare corruption
  } text_shape_t;

  logic  clk = 1'b0;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  sym_t  in_symbol;
  logic  in_last;
  logic  out_valid;
  logic  out_ready;
  pos_t  out_position;
  zval_t out_z_value;
  logic  out_overflow;
  logic  out_last_res;

  int    mismatches;
  int    pending;
  int    results_checked;
  int    strings_closed;
  int    strings_overflowed;
  int    requests_sent;
  bit    calm;  // both sides run without gaps or stalls while set

  always #5 clk = ~clk;

  z_array_builder_top #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_symbol   (in_symbol),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_position(out_position),
    .out_z_value (out_z_value),
    .out_overflow(out_overflow),
    .out_last_res(out_last_res)
  );

  // watches both channels, predicts the z array and keeps the failure count
  z_array_checker #(
    .MAX_LEN(MAX_LEN)
  ) u_zchk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_symbol         (in_symbol),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_position      (out_position),
    .out_z_value       (out_z_value),
    .out_overflow      (out_overflow),
    .out_last_res      (out_last_res),
    .mismatches        (mismatches),
    .pending           (pending),
    .results_checked   (results_checked),
    .strings_closed    (strings_closed),
    .strings_overflowed(strings_overflowed)
  );

  // one byte request; entered and left at a falling edge
  // valid is only dropped when a gap is taken, so back-to-back requests keep it high
  task automatic send_request(input sym_t sym, input logic fin);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_symbol <= sym;
    in_last   <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    @(negedge clk);
  endtask

  // a whole string of random content; span is the alphabet size or the longest period
  task automatic send_random_text(input int unsigned len, input text_shape_t shape,
                                  input int unsigned span);
    sym_t        pat[5];
    int unsigned period;
    sym_t        sym;
    foreach (pat[p]) pat[p] = sym_t'($urandom);
    period = $urandom_range(span, 1);
    for (int unsigned j = 0; j < len; j++) begin
      case (shape)
        SHAPE_NOISE:    sym = sym_t'($urandom);
        SHAPE_ALPHABET: sym = pat[$urandom_range(span - 1)];
        default:        sym = ($urandom_range(19) == 0) ? sym_t'($urandom) : pat[j % period];
      endcase
      send_request(sym, j == len - 1);
    end
  endtask

  initial begin : stimulus
    int unsigned random_start;
    in_valid  = 1'b0;
    in_symbol = '0;
    in_last   = 1'b0;
    calm      = 1'b0;
    rst_n     = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // shortest strings, with every symbol bit low and then high
    send_request(8'h00, 1'b1);
    send_request(8'hFF, 1'b1);
    // one repeated byte: each z value runs to the end of the string
    repeat (4) send_request(8'h55, 1'b0);
    send_request(8'h55, 1'b1);
    // alternating bytes, the window opened at position 2 is reused at every later position
    for (int j = 0; j < 6; j++) send_request((j % 2) ? 8'hFF : 8'h00, j == 5);
    // prior value longer than the room left in the window, so it is clamped
    send_request(8'h61, 1'b0);
    send_request(8'h61, 1'b0);
    send_request(8'h62, 1'b0);
    send_request(8'h61, 1'b0);
    send_request(8'h61, 1'b0);
    send_request(8'h62, 1'b0);
    send_request(8'h61, 1'b1);

    random_start = requests_sent;
    // exactly at capacity: every position in use, z of position one at its largest
    send_random_text(MAX_LEN, SHAPE_ALPHABET, 1);
    // past capacity, so the byte flagged last is itself dropped
    send_random_text(MAX_LEN + 2, SHAPE_PERIODIC, 3);
    // mostly short strings, with a stretch of full throughput in the middle
    while (requests_sent - random_start < RANDOM_ITEMS) begin
      calm = (requests_sent - random_start >= 150) && (requests_sent - random_start < 185);
      send_random_text($urandom_range(12, 1), text_shape_t'($urandom_range(2)),
                       $urandom_range(5, 1));
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d byte requests in %0d strings, %0d of them over capacity",
             requests_sent, strings_closed, strings_overflowed);
    $display("compared %0d z results against the prediction", results_checked);
    if (mismatches == 0) begin
      $display("PASS z_array_builder_top");
    end else begin
      $display("FAIL z_array_builder_top");
    end
    $finish;
  end

  // result side: random stalls, plus one long hold-off while the sender keeps offering
  // bytes, so the block backs up and drops in_ready
  initial begin : result_sink
    bit held;
    held      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_checked >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ends the run if neither channel moves a request for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("timed out after %0d quiet cycles, %0d results outstanding", quiet, pending);
    $display("FAIL z_array_builder_top");
    $finish;
  end

endmodule

/* z_array_builder_top.f */
sv/zab_pkg.sv
sv/zab_text_mem.sv
sv/z_array_builder_top.sv
verif/z_array_checker.sv
verif/z_array_builder_top_tb.sv
